### hdl/ectt_pkg.sv
// Shared types and constants of the epoch tagged capability table.
// Depends on nothing; used by every module of the block and by its checker.
package ectt_pkg;

  localparam int unsigned TABLE_SLOTS = 256;
  localparam int unsigned IDX_W       = $clog2(TABLE_SLOTS);
  localparam int unsigned ID_W        = 64;
  localparam int unsigned IDX_FIELD_W = 16;
  localparam int unsigned EPOCH_W     = ID_W - IDX_FIELD_W;
  localparam int unsigned REFS_W      = 32;
  localparam int unsigned GRP_W       = 16;
  localparam int unsigned NUM_GRP     = (TABLE_SLOTS + GRP_W - 1) / GRP_W;
  localparam int unsigned GRP_IDX_W   = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
  localparam int unsigned PE_W        = $clog2(GRP_W);

  localparam logic [EPOCH_W-1:0] EPOCH_MAX   = {EPOCH_W{1'b1}};
  localparam logic [EPOCH_W-1:0] EPOCH_RESET = EPOCH_W'(1);
  localparam logic [REFS_W-1:0]  REFS_MAX    = {REFS_W{1'b1}};

  typedef enum logic [2:0] {
    OP_ALLOC  = 3'd0,
    OP_LOOKUP = 3'd1,
    OP_INC    = 3'd2,
    OP_DEC    = 3'd3,
    OP_REVOKE = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_ID    = 2'd1,
    ST_EPOCH_OUT = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_CHECK,
    S_EPOCH,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e         operation;
    logic [63:0] cap_id;
    logic [7:0]  cap_kind;
    logic [63:0] rights;
    logic [31:0] owner;
    logic [63:0] resource;
    logic [63:0] path;
    logic        auth_safe;
  } cap_req_t;

  typedef struct packed {
    status_e     status;
    logic [63:0] new_id;
    logic [7:0]  entry_kind;
    logic [63:0] entry_rights;
    logic [31:0] entry_owner;
    logic [63:0] entry_resource;
    logic [63:0] entry_path;
    logic [31:0] entry_refs;
    logic        entry_safe;
  } cap_rsp_t;

  typedef struct packed {
    logic [7:0]         kind;
    logic [EPOCH_W-1:0] epoch;
    logic [63:0]        rights;
    logic [31:0]        owner;
    logic [63:0]        resource;
    logic [63:0]        path;
    logic [REFS_W-1:0]  refs;
    logic               safe;
  } entry_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] a;
    logic [EPOCH_W-1:0] b;
    logic               dec;
  } alu_in_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] sum;
    logic               a_max;
    logic               a_ge_b;
  } alu_out_t;

endpackage

### hdl/ectt_alu.sv
// Shared increment, decrement and compare unit for counts and epochs.
// Depends on ectt_pkg.
module ectt_alu (
  input  ectt_pkg::alu_in_t  alu_i,
  output ectt_pkg::alu_out_t alu_o
);
  import ectt_pkg::*;

  always_comb begin
    alu_o.sum    = alu_i.dec ? (alu_i.a - EPOCH_W'(1)) : (alu_i.a + EPOCH_W'(1));
    alu_o.a_max  = &alu_i.a;
    alu_o.a_ge_b = (alu_i.a >= alu_i.b);
  end

endmodule

### hdl/epoch_tagged_capability_table.sv
// Epoch tagged capability table: a 256-slot handle table with one item in flight at a time.
// A lookup, increment or decrement of a live id passes from acceptance through the decode
// state, which starts the registered slot read, the check state and the result state; a revoke
// that succeeds also passes an epoch state, and an alloc scans for a free slot instead. An id
// whose index is zero, out of range or free, an unknown operation and an alloc of type none
// go from decode straight to the result state. The free-slot scan over the in-use bitmap takes
// 16 slots a cycle, and the slot memory has a single port with a registered read; a result held
// off by the receiver keeps the next one waiting. In-use bits live in flip-flops cleared by
// reset, so the table is usable straight after reset with no clearing pass.
// Depends on ectt_pkg and ectt_alu.
module epoch_tagged_capability_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ectt_pkg::cap_req_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output ectt_pkg::cap_rsp_t out_data_o
);
  import ectt_pkg::*;

  state_e                 state_q, state_d;
  cap_req_t               req_q;
  cap_rsp_t               res_q, res_d;
  cap_rsp_t               out_q;
  logic                   out_valid_q, out_valid_d;
  logic [TABLE_SLOTS-1:0] used_q;
  logic [EPOCH_W-1:0]     cur_q, cur_d;
  logic [EPOCH_W-1:0]     ep_q, ep_d;
  logic [GRP_IDX_W-1:0]   grp_q, grp_d;

  entry_t                 mem_q [TABLE_SLOTS];
  entry_t                 rd_q;
  entry_t                 mem_wd;
  logic                   mem_we, mem_re;
  logic [IDX_W-1:0]       mem_addr;
  logic                   used_set, used_clr;

  alu_in_t                alu_in;
  alu_out_t               alu_out;

  logic [IDX_FIELD_W-1:0]   idx16;
  logic [IDX_W-1:0]         slot;
  logic                     id_miss;
  logic                     ep_match;
  logic [NUM_GRP*GRP_W-1:0] used_pad;
  logic [GRP_W-1:0]         free_bits;
  logic                     any_free;
  logic [PE_W-1:0]          pe;
  logic [IDX_W-1:0]         found;
  logic                     last_grp;
  logic                     out_free;

  ectt_alu u_alu (
    .alu_i (alu_in),
    .alu_o (alu_out)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // id decode
  assign idx16    = req_q.cap_id[IDX_FIELD_W-1:0];
  assign slot     = idx16[IDX_W-1:0];
  assign id_miss  = (idx16 == '0) || ({1'b0, idx16} >= (IDX_FIELD_W+1)'(TABLE_SLOTS))
                    || !used_q[slot];
  assign ep_match = (rd_q.epoch == req_q.cap_id[ID_W-1:IDX_FIELD_W]);

  // slot zero and padding beyond the table count as taken
  always_comb begin
    for (int i = 0; i < NUM_GRP*GRP_W; i++) begin
      if (i == 0 || i >= TABLE_SLOTS) begin
        used_pad[i] = 1'b1;
      end else begin
        used_pad[i] = used_q[i];
      end
    end
  end

  assign free_bits = ~used_pad[grp_q*GRP_W +: GRP_W];
  assign any_free  = |free_bits;
  assign last_grp  = (grp_q == GRP_IDX_W'(NUM_GRP-1));

  // lowest free slot in the current group
  always_comb begin
    pe = '0;
    for (int i = GRP_W-1; i >= 0; i--) begin
      if (free_bits[i]) begin
        pe = PE_W'(i);
      end
    end
  end

  assign found = IDX_W'({grp_q, pe});

  // shared unit operands: refcount by default, slot epoch on revoke, then the new epoch
  always_comb begin
    alu_in.a   = EPOCH_W'(rd_q.refs);
    alu_in.b   = cur_q;
    alu_in.dec = (req_q.operation == OP_DEC);
    if (state_q == S_CHECK && req_q.operation == OP_REVOKE) begin
      alu_in.a   = rd_q.epoch;
      alu_in.dec = 1'b0;
    end else if (state_q == S_EPOCH) begin
      alu_in.a   = ep_q;
      alu_in.dec = 1'b0;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (req_q.operation) inside
          OP_ALLOC: state_d = (req_q.cap_kind == '0) ? S_RESP : S_SCAN;
          OP_LOOKUP, OP_INC, OP_DEC, OP_REVOKE: state_d = id_miss ? S_RESP : S_CHECK;
          default: state_d = S_RESP;
        endcase
      end
      S_SCAN: begin
        if (any_free || last_grp) state_d = S_RESP;
      end
      S_CHECK: begin
        if (ep_match && req_q.operation == OP_REVOKE && !alu_out.a_max) begin
          state_d = S_EPOCH;
        end else begin
          state_d = S_RESP;
        end
      end
      S_EPOCH: state_d = S_RESP;
      S_RESP: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    res_d       = res_q;
    cur_d       = cur_q;
    ep_d        = ep_q;
    grp_d       = grp_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = slot;
    mem_wd      = rd_q;
    used_set    = 1'b0;
    used_clr    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      S_IDLE: ;
      S_DECODE: begin
        res_d        = '0;
        res_d.status = ST_BAD_ID;
        grp_d        = '0;
        if (req_q.operation == OP_ALLOC) begin
          res_d.status = ST_FULL;
        end else begin
          mem_re = !id_miss;
        end
      end
      S_SCAN: begin
        mem_addr = found;
        if (any_free) begin
          mem_we          = 1'b1;
          used_set        = 1'b1;
          mem_wd.kind     = req_q.cap_kind;
          mem_wd.epoch    = cur_q;
          mem_wd.rights   = req_q.rights;
          mem_wd.owner    = req_q.owner;
          mem_wd.resource = req_q.resource;
          mem_wd.path     = req_q.path;
          mem_wd.refs     = REFS_W'(1);
          mem_wd.safe     = req_q.auth_safe;
          res_d.status    = ST_OK;
          res_d.new_id    = {cur_q, IDX_FIELD_W'(found)};
        end else begin
          grp_d = grp_q + GRP_IDX_W'(1);
        end
      end
      S_CHECK: begin
        if (ep_match) begin
          res_d.status = ST_OK;
          case (req_q.operation)
            OP_LOOKUP: begin
              res_d.entry_kind     = rd_q.kind;
              res_d.entry_rights   = rd_q.rights;
              res_d.entry_owner    = rd_q.owner;
              res_d.entry_resource = rd_q.resource;
              res_d.entry_path     = rd_q.path;
              res_d.entry_refs     = rd_q.refs;
              res_d.entry_safe     = rd_q.safe;
            end
            OP_INC: begin
              if (rd_q.refs != REFS_MAX) begin
                mem_we      = 1'b1;
                mem_wd.refs = alu_out.sum[REFS_W-1:0];
              end
            end
            OP_DEC: begin
              mem_we = 1'b1;
              if (rd_q.refs <= REFS_W'(1)) begin
                used_clr     = 1'b1;
                mem_wd       = '0;
                mem_wd.epoch = rd_q.epoch;
              end else begin
                mem_wd.refs = alu_out.sum[REFS_W-1:0];
              end
            end
            OP_REVOKE: begin
              if (alu_out.a_max) begin
                res_d.status = ST_EPOCH_OUT;
              end else begin
                mem_we       = 1'b1;
                used_clr     = 1'b1;
                mem_wd       = '0;
                mem_wd.epoch = alu_out.sum;
                ep_d         = alu_out.sum;
              end
            end
            default: ;
          endcase
        end
      end
      S_EPOCH: begin
        // push the global epoch past the revoked slot, saturating at the top
        if (alu_out.a_ge_b) begin
          cur_d = alu_out.a_max ? EPOCH_MAX : alu_out.sum;
        end
      end
      S_RESP: begin
        if (out_free) out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      used_q      <= '0;
      cur_q       <= EPOCH_RESET;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      cur_q       <= cur_d;
      if (used_set) used_q[mem_addr] <= 1'b1;
      if (used_clr) used_q[mem_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
    if (state_q == S_RESP && out_free) out_q <= res_q;
    res_q <= res_d;
    ep_q  <= ep_d;
    grp_q <= grp_d;
  end

  // slot memory, one port with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_addr] <= mem_wd;
    if (mem_re) rd_q <= mem_q[mem_addr];
  end

endmodule

### hdl/ectt_checker.sv
// Port-level checks for the epoch tagged capability table, bound to the top level.
// Depends on ectt_pkg and epoch_tagged_capability_table.
module ectt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input ectt_pkg::cap_rsp_t out_data_o
);
  import ectt_pkg::*;

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again straight after an item");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != ST_OK |->
      out_data_o.new_id == '0 && out_data_o.entry_kind == '0 && out_data_o.entry_refs == '0)
    else $error("failed item carries payload");

  a_new_id_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.new_id != '0 |->
      out_data_o.new_id[IDX_FIELD_W-1:0] != '0 && out_data_o.entry_kind == '0)
    else $error("alloc id names slot zero or mixes lookup data");

  a_live_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.entry_refs != '0 |-> out_data_o.entry_kind != '0)
    else $error("looked-up entry with references has no type");

endmodule

bind epoch_tagged_capability_table ectt_checker u_ectt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

### dv/epoch_tagged_capability_table_tb.sv
// Self-checking testbench of the epoch tagged capability table: valid/ready stimulus,
// a shadow copy of the slot table predicting every result, field by field comparison.
// Depends on ectt_pkg and epoch_tagged_capability_table.
`timescale 1ns / 100ps

module epoch_tagged_capability_table_tb;
  import ectt_pkg::*;

  localparam int          LIMIT_CYCLES   = 400000;
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          LONG_HOLD      = 300;
  localparam int          OP_FIRST_SPARE = int'(OP_REVOKE) + 1;
  localparam int          OP_LAST_CODE   = (1 << $bits(op_e)) - 1;
  localparam logic [7:0]  KIND_NONE      = '0;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  cap_req_t in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  cap_rsp_t out_data_o;

  cap_req_t           cap_req_q[$];
  cap_rsp_t           rsp_expect_q[$];
  entry_t             shadow[TABLE_SLOTS];
  logic [EPOCH_W-1:0] shadow_epoch;

  int n_offered      = 0;
  int n_accepted     = 0;
  int n_fail         = 0;
  int n_cycles       = 0;
  int send_gap_pct   = 8;
  int recv_stall_pct = 51;
  int hold_left      = 0;
  bit hold_trigger   = 1'b0;
  bit hold_done      = 1'b0;

  epoch_tagged_capability_table dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // applies one item to the shadow table and returns the result it should give
  function automatic cap_rsp_t apply_to_shadow(input cap_req_t req);
    cap_rsp_t           rsp;
    int unsigned        hit;
    int unsigned        free_slot;
    logic [EPOCH_W-1:0] kept;
    rsp        = '0;
    rsp.status = ST_BAD_ID;
    hit        = 0;
    free_slot  = 0;
    if (req.cap_id[15:0] != '0 && req.cap_id[15:0] < TABLE_SLOTS) begin
      if (shadow[req.cap_id[15:0]].kind != KIND_NONE &&
          shadow[req.cap_id[15:0]].epoch == req.cap_id[63:16]) begin
        hit = req.cap_id[15:0];
      end
    end
    case (req.operation)
      OP_ALLOC: begin
        rsp.status = ST_FULL;
        if (req.cap_kind != KIND_NONE) begin
          for (int i = 1; i < TABLE_SLOTS && free_slot == 0; i++) begin
            if (shadow[i].kind == KIND_NONE) free_slot = i;
          end
          if (free_slot != 0) begin
            shadow[free_slot].kind     = req.cap_kind;
            shadow[free_slot].epoch    = shadow_epoch;
            shadow[free_slot].rights   = req.rights;
            shadow[free_slot].owner    = req.owner;
            shadow[free_slot].resource = req.resource;
            shadow[free_slot].path     = req.path;
            shadow[free_slot].safe     = req.auth_safe;
            shadow[free_slot].refs     = REFS_W'(1);
            rsp.new_id = {shadow_epoch, IDX_FIELD_W'(free_slot)};
            rsp.status = ST_OK;
          end
        end
      end
      OP_LOOKUP: begin
        if (hit != 0) begin
          rsp.status         = ST_OK;
          rsp.entry_kind     = shadow[hit].kind;
          rsp.entry_rights   = shadow[hit].rights;
          rsp.entry_owner    = shadow[hit].owner;
          rsp.entry_resource = shadow[hit].resource;
          rsp.entry_path     = shadow[hit].path;
          rsp.entry_refs     = shadow[hit].refs;
          rsp.entry_safe     = shadow[hit].safe;
        end
      end
      OP_INC: begin
        if (hit != 0) begin
          rsp.status = ST_OK;
          if (shadow[hit].refs != REFS_MAX) shadow[hit].refs = shadow[hit].refs + 1'b1;
        end
      end
      OP_DEC: begin
        if (hit != 0) begin
          rsp.status = ST_OK;
          if (shadow[hit].refs <= 1) begin
            // slot freed, epoch survives
            kept              = shadow[hit].epoch;
            shadow[hit]       = '0;
            shadow[hit].epoch = kept;
          end else begin
            shadow[hit].refs = shadow[hit].refs - 1'b1;
          end
        end
      end
      OP_REVOKE: begin
        if (hit != 0) begin
          if (shadow[hit].epoch == EPOCH_MAX) begin
            rsp.status = ST_EPOCH_OUT;
          end else begin
            rsp.status        = ST_OK;
            kept              = shadow[hit].epoch + 1'b1;
            shadow[hit]       = '0;
            shadow[hit].epoch = kept;
            // global epoch moves past the revoked slot, saturating at the top
            if (shadow_epoch <= kept) begin
              shadow_epoch = (kept == EPOCH_MAX) ? EPOCH_MAX : kept + 1'b1;
            end
          end
        end
      end
      default: rsp.status = ST_BAD_ID;
    endcase
    return rsp;
  endfunction

  function automatic logic [63:0] id_of(input logic [EPOCH_W-1:0] epoch,
                                        input logic [IDX_FIELD_W-1:0] slot);
    return {epoch, slot};
  endfunction

  function automatic cap_req_t make_req(input op_e op, input logic [63:0] id,
                                        input logic [7:0] kind, input logic [63:0] fill,
                                        input logic safe);
    cap_req_t r;
    r.operation = op;
    r.cap_id    = id;
    r.cap_kind  = kind;
    r.rights    = fill;
    r.owner     = fill[31:0];
    r.resource  = fill;
    r.path      = fill;
    r.auth_safe = safe;
    return r;
  endfunction

  // the next item is chosen only once the shadow table holds every earlier one
  task automatic wait_drained();
    do @(negedge clk_i); while (n_accepted != n_offered);
  endtask

  task automatic offer(input cap_req_t r);
    wait_drained();
    cap_req_q.push_back(r);
    n_offered++;
  endtask

  task automatic offer_random_item(input int alloc_pct);
    cap_req_t    r;
    int unsigned live[$];
    int unsigned idle[$];
    int unsigned s;
    int          roll;
    wait_drained();
    for (int i = 1; i < TABLE_SLOTS; i++) begin
      if (shadow[i].kind != KIND_NONE) live.push_back(i);
      else idle.push_back(i);
    end
    r.cap_kind  = ($urandom_range(99) < 5) ? KIND_NONE : 8'($urandom_range(255, 1));
    r.rights    = {$urandom, $urandom};
    r.owner     = $urandom;
    r.resource  = {$urandom, $urandom};
    r.path      = {$urandom, $urandom};
    r.auth_safe = 1'($urandom);
    roll = $urandom_range(99);
    if (roll < alloc_pct) begin
      r.operation = OP_ALLOC;
    end else begin
      roll = $urandom_range(99);
      if (roll < 30)      r.operation = OP_LOOKUP;
      else if (roll < 50) r.operation = OP_INC;
      else if (roll < 75) r.operation = OP_DEC;
      else if (roll < 93) r.operation = OP_REVOKE;
      else                r.operation = op_e'($urandom_range(OP_LAST_CODE, OP_FIRST_SPARE));
    end
    // mostly live ids, then stale, free, zero index, out of range and plain noise
    r.cap_id = {$urandom, $urandom};
    roll = $urandom_range(99);
    if (roll < 75 && live.size() != 0) begin
      s = live[$urandom_range(live.size() - 1)];
      r.cap_id = id_of(shadow[s].epoch, s);
    end else if (roll < 83 && live.size() != 0) begin
      s = live[$urandom_range(live.size() - 1)];
      r.cap_id = id_of(shadow[s].epoch ^ EPOCH_W'($urandom_range(3, 1)), s);
    end else if (roll < 88 && idle.size() != 0) begin
      s = idle[$urandom_range(idle.size() - 1)];
      r.cap_id = id_of(shadow[s].epoch, s);
    end else if (roll < 92) begin
      r.cap_id[15:0] = '0;
    end else if (roll < 96) begin
      r.cap_id = id_of(shadow_epoch - 1'b1, 16'($urandom_range(65535, TABLE_SLOTS)));
    end
    cap_req_q.push_back(r);
    n_offered++;
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      n_fail++;
    end
  endtask

  // driver: the shadow table advances on every accepted item
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        rsp_expect_q.push_back(apply_to_shadow(in_data_i));
        n_accepted++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (cap_req_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= cap_req_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver with one long hold-off so that the block backs up
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (hold_trigger && !hold_done) begin
      out_ready_i <= 1'b0;
      hold_left   <= LONG_HOLD;
      hold_done   <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    cap_rsp_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (rsp_expect_q.size() == 0) begin
        $display("%0t: result with nothing pending, expected none, got status %0d id %h",
                 $time, out_data_o.status, out_data_o.new_id);
        n_fail++;
      end else begin
        want = rsp_expect_q.pop_front();
        check_field("status", want.status, out_data_o.status);
        check_field("new_id", want.new_id, out_data_o.new_id);
        check_field("entry_kind", want.entry_kind, out_data_o.entry_kind);
        check_field("entry_rights", want.entry_rights, out_data_o.entry_rights);
        check_field("entry_owner", want.entry_owner, out_data_o.entry_owner);
        check_field("entry_resource", want.entry_resource, out_data_o.entry_resource);
        check_field("entry_path", want.entry_path, out_data_o.entry_path);
        check_field("entry_refs", want.entry_refs, out_data_o.entry_refs);
        check_field("entry_safe", want.entry_safe, out_data_o.entry_safe);
      end
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles == LIMIT_CYCLES) begin
      $display("** epoch_tagged_capability_table: FAILED **");
      $finish;
    end
  end

  initial begin : stimulus
    int busy;
    foreach (shadow[i]) shadow[i] = '0;
    shadow_epoch = EPOCH_RESET;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // empty table, type none, extremes of the payload
    offer(make_req(OP_LOOKUP, id_of(1, 1), KIND_NONE, '0, 1'b0));
    offer(make_req(OP_ALLOC, '0, KIND_NONE, '1, 1'b1));
    offer(make_req(OP_ALLOC, '1, 8'hFF, '1, 1'b1));
    offer(make_req(OP_ALLOC, '0, 8'h01, '0, 1'b0));
    offer(make_req(OP_LOOKUP, id_of(1, 1), KIND_NONE, '0, 1'b0));
    offer(make_req(OP_LOOKUP, id_of(1, 2), KIND_NONE, '0, 1'b0));
    offer(make_req(OP_INC, id_of(1, 1), KIND_NONE, '0, 1'b0));
    offer(make_req(OP_LOOKUP, id_of(1, 1), KIND_NONE, '0, 1'b0));
    offer(make_req(OP_DEC, id_of(1, 1), KIND_NONE, '0, 1'b0));
    // malformed and stale ids on every id operation
    offer(make_req(OP_LOOKUP, id_of(1, 0), KIND_NONE, '0, 1'b0));
    offer(make_req(OP_INC, id_of(1, TABLE_SLOTS), KIND_NONE, '0, 1'b0));
    offer(make_req(OP_DEC, '1, KIND_NONE, '0, 1'b0));
    offer(make_req(OP_REVOKE, id_of(2, 1), KIND_NONE, '0, 1'b0));
    for (int c = OP_FIRST_SPARE; c <= OP_LAST_CODE; c++) begin
      offer(make_req(op_e'(c), id_of(1, 1), 8'h01, '1, 1'b1));
    end
    // revoke leaves old ids stale and moves the global epoch on
    offer(make_req(OP_REVOKE, id_of(1, 1), KIND_NONE, '0, 1'b0));
    offer(make_req(OP_LOOKUP, id_of(1, 1), KIND_NONE, '0, 1'b0));
    offer(make_req(OP_ALLOC, '0, 8'h80, 64'hA5A5_5A5A_0F0F_F0F0, 1'b1));
    offer(make_req(OP_LOOKUP, id_of(3, 1), KIND_NONE, '0, 1'b0));
    // last reference dropped frees the slot
    offer(make_req(OP_DEC, id_of(1, 2), KIND_NONE, '0, 1'b0));
    offer(make_req(OP_LOOKUP, id_of(1, 2), KIND_NONE, '0, 1'b0));
    offer(make_req(OP_REVOKE, id_of(1, 2), KIND_NONE, '0, 1'b0));
    offer(make_req(OP_ALLOC, '0, 8'h7E, 64'h0123_4567_89AB_CDEF, 1'b0));
    offer(make_req(OP_LOOKUP, id_of(3, 2), KIND_NONE, '0, 1'b0));

    for (int n = 0; n < 60; n++) begin
      if (n == 30) hold_trigger = 1'b1;
      offer_random_item(45);
    end
    send_gap_pct   = 51;
    recv_stall_pct = 8;
    for (int n = 0; n < 60; n++) offer_random_item(45);
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    for (int n = 0; n < 60; n++) offer_random_item(45);

    // fill every slot, then work on a full table
    do begin
      offer_random_item(100);
      wait_drained();
      busy = 0;
      for (int i = 1; i < TABLE_SLOTS; i++) begin
        if (shadow[i].kind != KIND_NONE) busy++;
      end
    end while (busy < TABLE_SLOTS - 1);
    for (int n = 0; n < 3; n++) offer_random_item(100);
    for (int n = 0; n < 30; n++) offer_random_item(50);

    wait_drained();
    while (rsp_expect_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (n_fail == 0) begin
      $display("** epoch_tagged_capability_table: PASSED **");
    end else begin
      $display("** epoch_tagged_capability_table: FAILED **");
    end
    $finish;
  end

endmodule
